FILE: hdl/rdq_pkg.sv
package rdq_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int REQ_W          = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR   = 3'd0,
		REQ_LOAD    = 3'd1,
		REQ_REVERSE = 3'd2,
		REQ_DELETE  = 3'd3,
		REQ_READ    = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ERROR = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_WRITE = 2'd1,
		MEM_READ  = 2'd2
	} mem_op_t;

	// classified request as handed from front to back
	typedef struct packed {
		mem_op_t op;
		status_t status;
		logic    last;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage

FILE: hdl/rdq_front.sv
module rdq_front #(
	parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
	parameter int PW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [rdq_pkg::REQ_W-1:0] req_type,
	input  logic [DATA_WIDTH-1:0]     value,
	output rdq_pkg::ctl_t             ctl,
	output logic [PW-1:0]             addr,
	output logic [DATA_WIDTH-1:0]     wdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	logic [PW-1:0] front_q, front_n;
	logic [PW-1:0] back_q, back_n;
	logic [CW-1:0] count_q, count_n;
	logic          rev_q, rev_n;
	logic          err_q, err_n;
	logic [PW-1:0] front_inc, back_inc, back_dec;

	// back_q points at the next free slot, i.e. front + count wrapped
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign back_inc  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;
	assign back_dec  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;
	assign wdata     = value;

	always_comb begin
		front_n    = front_q;
		back_n     = back_q;
		count_n    = count_q;
		rev_n      = rev_q;
		err_n      = err_q;
		ctl.op     = rdq_pkg::MEM_NONE;
		ctl.status = rdq_pkg::ST_OK;
		ctl.last   = 1'b0;
		addr       = back_q;
		unique case (req_type) inside
			rdq_pkg::REQ_CLEAR: begin
				front_n = '0;
				back_n  = '0;
				count_n = '0;
				rev_n   = 1'b0;
				err_n   = 1'b0;
			end
			rdq_pkg::REQ_LOAD: begin
				if (err_q) begin
					ctl.status = rdq_pkg::ST_ERROR;
				end else if (count_q == FULL_CNT) begin
					ctl.status = rdq_pkg::ST_FULL;
				end else begin
					ctl.op  = rdq_pkg::MEM_WRITE;
					back_n  = back_inc;
					count_n = count_q + 1'b1;
				end
			end
			rdq_pkg::REQ_REVERSE: begin
				if (err_q) begin
					ctl.status = rdq_pkg::ST_ERROR;
				end else begin
					rev_n = ~rev_q;
				end
			end
			rdq_pkg::REQ_DELETE, rdq_pkg::REQ_READ: begin
				if (err_q) begin
					ctl.status = rdq_pkg::ST_ERROR;
				end else if (count_q == '0) begin
					if (req_type == rdq_pkg::REQ_DELETE) begin
						err_n      = 1'b1;
						ctl.status = rdq_pkg::ST_ERROR;
					end else begin
						ctl.status = rdq_pkg::ST_EMPTY;
					end
				end else begin
					// logical front is the physical back when reversed
					if (rev_q) begin
						addr   = back_dec;
						back_n = back_dec;
					end else begin
						addr    = front_q;
						front_n = front_inc;
					end
					count_n = count_q - 1'b1;
					if (req_type == rdq_pkg::REQ_READ) begin
						ctl.op   = rdq_pkg::MEM_READ;
						ctl.last = (count_q == ONE_CNT);
					end
				end
			end
			default: begin
				// unused codes change nothing, but still bounce on a set error flag
				if (err_q) begin
					ctl.status = rdq_pkg::ST_ERROR;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			front_q <= front_n;
			back_q  <= back_n;
			count_q <= count_n;
			rev_q   <= rev_n;
			err_q   <= err_n;
		end
	end

endmodule

FILE: hdl/rdq_queue.sv
module rdq_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] slot_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: hdl/rdq_back.sv
module rdq_back #(
	parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
	parameter int PW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  rdq_pkg::ctl_t                ctl,
	input  logic [PW-1:0]                addr,
	input  logic [DATA_WIDTH-1:0]        wdata,
	output logic                         pop,
	output logic                         done,
	output logic [rdq_pkg::STATUS_W-1:0] status,
	output logic [DATA_WIDTH-1:0]        data_out,
	output logic                         last
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_s1;
	rdq_pkg::ctl_t         ctl_s1;
	logic                  valid_s1;

	// never stalls: one queued op per cycle
	assign pop = valid;

	always_ff @(posedge clk) begin
		if (valid && ctl.op == rdq_pkg::MEM_WRITE) begin
			mem[addr] <= wdata;
		end
		if (valid && ctl.op == rdq_pkg::MEM_READ) begin
			rdata_s1 <= mem[addr];
		end
		ctl_s1 <= ctl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	assign done     = valid_s1;
	assign status   = ctl_s1.status;
	assign last     = ctl_s1.last;
	assign data_out = (ctl_s1.op == rdq_pkg::MEM_READ) ? rdata_s1 : '0;

endmodule

FILE: hdl/reversible_deque_top.sv
// done rises after an accepted beat has passed through the two-entry queue and the back's result register
// throughput: one request per cycle while busy is low, set by the single port of the element memory
// busy rises only if the two-entry queue fills, which a non-stalling back end prevents
// results cannot be held off: each one shows on done for exactly one cycle
// reset (arst_n low, asynchronous): empty deque, not reversed, error flag clear
// element memory is not cleared; only slots written by a load are ever read
module reversible_deque_top #(
	parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [rdq_pkg::REQ_W-1:0]    req_type,
	input  logic [DATA_WIDTH-1:0]        value,
	output logic                         done,
	output logic [rdq_pkg::STATUS_W-1:0] status,
	output logic [DATA_WIDTH-1:0]        data_out,
	output logic                         last
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW = rdq_pkg::CTL_W + PW + DATA_WIDTH;

	// front side: request beat and its classification
	logic                  accept;
	rdq_pkg::ctl_t         f_ctl;
	logic [PW-1:0]         f_addr;
	logic [DATA_WIDTH-1:0] f_wdata;

	// queue between front and back
	logic [QW-1:0]         q_dout;
	logic                  q_empty, q_full, q_pop;

	// back side: memory op pulled from the queue
	rdq_pkg::ctl_t         b_ctl;
	logic [PW-1:0]         b_addr;
	logic [DATA_WIDTH-1:0] b_wdata;

	// a beat is taken whenever the queue has room
	assign busy   = q_full;
	assign accept = start && !busy;

	// front owns pointers, count, reverse bit and error flag;
	// it resolves status and last right away and only leaves the memory access
	rdq_front #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.PW         (PW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.value    (value),
		.ctl      (f_ctl),
		.addr     (f_addr),
		.wdata    (f_wdata)
	);

	// ops leave the queue in order, so a load's write always lands
	// before any later read of the same slot
	rdq_queue #(
		.W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    ({f_ctl, f_addr, f_wdata}),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign {b_ctl, b_addr, b_wdata} = q_dout;

	// back does the memory access and drives the result beat
	rdq_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.PW         (PW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (!q_empty),
		.ctl      (b_ctl),
		.addr     (b_addr),
		.wdata    (b_wdata),
		.pop      (q_pop),
		.done     (done),
		.status   (status),
		.data_out (data_out),
		.last     (last)
	);

endmodule

FILE: hdl/rdq_checker.sv
module rdq_checker #(
	parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [rdq_pkg::REQ_W-1:0]    req_type,
	input logic                         done,
	input logic [rdq_pkg::STATUS_W-1:0] status,
	input logic [DATA_WIDTH-1:0]        data_out,
	input logic                         last
);

	logic [1:0] acc_q;
	logic [1:0] clr_q;

	// follow accepted beats to their result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 2'b00;
			clr_q <= 2'b00;
		end else begin
			acc_q <= {acc_q[0], start && !busy};
			clr_q <= {clr_q[0], start && !busy && req_type == rdq_pkg::REQ_CLEAR};
		end
	end

	a_one_result_per_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done == acc_q[1])
		else $error("result strobe does not match accepted beats");

	a_clear_ok: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q[1] |-> (done && status == rdq_pkg::ST_OK && last == 1'b0))
		else $error("clear did not answer ok");

	a_no_data_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != rdq_pkg::ST_OK) |-> (data_out == '0 && last == 1'b0))
		else $error("failed request carries data or last");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("request queue filled up");

endmodule

bind reversible_deque_top rdq_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_rdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req_type (req_type),
	.done     (done),
	.status   (status),
	.data_out (data_out),
	.last     (last)
);
